/* sv/s2c_pkg.sv */
// Package for the seconds-to-calendar converter.
// Holds the microcode table, the calendar constants and the small tables.
// No dependencies.
`default_nettype none

package s2c_pkg;

  localparam logic [31:0] LAST_SECOND = 32'd4102444799;
  localparam logic [11:0] BASE_YEAR   = 12'd1970;
  localparam logic [11:0] CENTURY_REF = 12'd1900;
  localparam int unsigned STEP_W      = 5;

  // Micro-operations of the sequencer.
  typedef enum logic [3:0] {
    OP_WAIT,
    OP_DIV_QUO,
    OP_DIV_REM,
    OP_SAVE_DAYS,
    OP_SAVE_HOUR,
    OP_SAVE_MIN,
    OP_YEAR,
    OP_MONTH,
    OP_WD_PREP,
    OP_WD_ADD,
    OP_OUT
  } op_t;

  // Divisor selection for the constant dividers.
  typedef enum logic [1:0] {
    DIV_DAY,
    DIV_HOUR,
    DIV_MIN,
    DIV_WEEK
  } dsel_t;

  typedef struct packed {
    op_t   op;
    dsel_t dsel;
  } ucode_t;

  localparam logic [STEP_W-1:0] STEP_WAIT = '0;

  // The program. A looping step stays put until its condition holds,
  // every other step falls through; the output step returns to the start.
  function automatic ucode_t ucode_rom(input logic [STEP_W-1:0] step);
    ucode_t w;
    w = '{op: OP_WAIT, dsel: DIV_DAY};
    unique case (step)
      5'd0:    w = '{op: OP_WAIT,      dsel: DIV_DAY};
      5'd1:    w = '{op: OP_DIV_QUO,   dsel: DIV_DAY};
      5'd2:    w = '{op: OP_DIV_REM,   dsel: DIV_DAY};
      5'd3:    w = '{op: OP_SAVE_DAYS, dsel: DIV_DAY};
      5'd4:    w = '{op: OP_DIV_QUO,   dsel: DIV_HOUR};
      5'd5:    w = '{op: OP_DIV_REM,   dsel: DIV_HOUR};
      5'd6:    w = '{op: OP_SAVE_HOUR, dsel: DIV_HOUR};
      5'd7:    w = '{op: OP_DIV_QUO,   dsel: DIV_MIN};
      5'd8:    w = '{op: OP_DIV_REM,   dsel: DIV_MIN};
      5'd9:    w = '{op: OP_SAVE_MIN,  dsel: DIV_MIN};
      5'd10:   w = '{op: OP_YEAR,      dsel: DIV_DAY};
      5'd11:   w = '{op: OP_MONTH,     dsel: DIV_DAY};
      5'd12:   w = '{op: OP_WD_PREP,   dsel: DIV_WEEK};
      5'd13:   w = '{op: OP_WD_ADD,    dsel: DIV_WEEK};
      5'd14:   w = '{op: OP_DIV_QUO,   dsel: DIV_WEEK};
      5'd15:   w = '{op: OP_DIV_REM,   dsel: DIV_WEEK};
      5'd16:   w = '{op: OP_OUT,       dsel: DIV_WEEK};
      default: w = '{op: OP_WAIT,      dsel: DIV_DAY};
    endcase
    return w;
  endfunction

  // Quotient by a constant. The power of two in the divisor is shifted off and the
  // odd part is divided by multiplying with its rounded-up reciprocal; for the
  // operand ranges that reach each divisor the truncated product is exact.
  function automatic logic [15:0] div_quo(input dsel_t sel, input logic [31:0] n);
    logic [50:0] pd;
    logic [26:0] ph;
    logic [20:0] pm;
    logic [18:0] pw;
    logic [15:0] q;
    pd = {26'd0, n[31:7]} * {25'd0, 26'd50903317};
    ph = {14'd0, n[16:4]} * {13'd0, 14'd9321};
    pm = {11'd0, n[11:2]} * {10'd0, 11'd1093};
    pw = {10'd0, n[8:0]} * {9'd0, 10'd586};
    q = pd[50:35];
    unique case (sel)
      DIV_DAY:  q = pd[50:35];
      DIV_HOUR: q = {10'd0, ph[26:21]};
      DIV_MIN:  q = {9'd0, pm[20:14]};
      DIV_WEEK: q = {9'd0, pw[18:12]};
      default:  q = pd[50:35];
    endcase
    return q;
  endfunction

  // Remainder to match the quotient above: the odd part's remainder with the
  // shifted-off low bits put back underneath.
  function automatic logic [31:0] div_rem(input dsel_t sel, input logic [31:0] n,
                                          input logic [15:0] q);
    logic [25:0] td;
    logic [12:0] th;
    logic [9:0]  tm;
    logic [8:0]  tw;
    logic [31:0] r;
    td = {1'b0, n[31:7]} - ({10'd0, q} * 26'd675);
    th = n[16:4] - ({7'd0, q[5:0]} * 13'd225);
    tm = n[11:2] - ({3'd0, q[6:0]} * 10'd15);
    tw = n[8:0] - ({2'd0, q[6:0]} * 9'd7);
    r = {15'd0, td[9:0], n[6:0]};
    unique case (sel)
      DIV_DAY:  r = {15'd0, td[9:0], n[6:0]};
      DIV_HOUR: r = {20'd0, th[7:0], n[3:0]};
      DIV_MIN:  r = {26'd0, tm[3:0], n[1:0]};
      DIV_WEEK: r = {29'd0, tw[2:0]};
      default:  r = {15'd0, td[9:0], n[6:0]};
    endcase
    return r;
  endfunction

  function automatic logic [4:0] month_len(input logic [3:0] mon, input logic leap);
    logic [4:0] n;
    n = 5'd31;
    unique case (mon)
      4'd1:                  n = leap ? 5'd29 : 5'd28;
      4'd3, 4'd5, 4'd8, 4'd10: n = 5'd30;
      default:               n = 5'd31;
    endcase
    return n;
  endfunction

  function automatic logic [2:0] month_offset(input logic [3:0] mon);
    logic [2:0] o;
    o = 3'd0;
    unique case (mon)
      4'd0, 4'd9:         o = 3'd0;
      4'd1, 4'd2, 4'd10:  o = 3'd3;
      4'd3, 4'd6:         o = 3'd6;
      4'd4:               o = 3'd1;
      4'd5, 4'd11:        o = 3'd5;
      4'd7:               o = 3'd2;
      4'd8:               o = 3'd5;
      default:            o = 3'd0;
    endcase
    if (mon == 4'd5) o = 3'd4;
    return o;
  endfunction

endpackage

`default_nettype wire

/* sv/seconds_to_calendar_core.sv */
// Seconds-to-calendar converter: microcoded sequencer and its datapath.
// Uses s2c_pkg for the microcode table, divisor and month tables.
//
//   Channel | Direction | Handshake            | Word
//   in_     | input     | in_valid / in_stall  | epoch_seconds
//   out_    | output    | out_valid / out_stall| year .. weekday, beyond_range
//
// Each word passes through fifteen single steps of the microcode (each division by a
// constant is a reciprocal multiply step and a remainder step), one step per year
// from 1970 (up to 130) and one per month (up to 12).
// Reset clears the step counter and the output valid flag.
// A finished word waits in the output register; the next word is taken and
// converted meanwhile, and the sequencer only halts at its final step while
// the output register is still full and stalled.
`default_nettype none

module seconds_to_calendar_core (
  input  wire logic        clk,
  input  wire logic        rst_n,
  input  wire logic        in_valid,
  output logic             in_stall,
  input  wire logic [31:0] in_epoch_seconds,
  output logic             out_valid,
  input  wire logic        out_stall,
  output logic [11:0]      out_year,
  output logic [3:0]       out_month,
  output logic [4:0]       out_day_of_month,
  output logic [4:0]       out_hour,
  output logic [5:0]       out_minute,
  output logic [5:0]       out_second,
  output logic [2:0]       out_weekday,
  output logic             out_beyond_range
);

  logic [s2c_pkg::STEP_W-1:0] step_r, step_nxt;
  logic [31:0] num_r, num_nxt;
  logic [15:0] quo_r, quo_nxt;
  logic [15:0] days_r, days_nxt;
  logic [11:0] year_r, year_nxt;
  logic [3:0]  mon_r, mon_nxt;
  logic [4:0]  hour_r, hour_nxt;
  logic [5:0]  min_r, min_nxt;
  logic [5:0]  sec_r, sec_nxt;
  logic        flag_r, flag_nxt;
  logic        out_valid_r;

  s2c_pkg::ucode_t uw;
  logic        leap;
  logic [8:0]  ylen;
  logic [4:0]  mlen;
  logic        year_done;
  logic        mon_done;
  logic        out_free;
  logic        load_out;
  logic [7:0]  yl;

  assign uw     = s2c_pkg::ucode_rom(step_r);
  // Within 1970..2099 the century rule only touches 2000, which is a leap year.
  assign leap      = (year_r[1:0] == 2'd0);
  assign ylen      = leap ? 9'd366 : 9'd365;
  assign mlen      = s2c_pkg::month_len(mon_r, leap);
  assign year_done = (days_r < {7'd0, ylen});
  assign mon_done  = (mon_r == 4'd11) || (days_r < {11'd0, mlen});
  assign out_free  = !out_valid_r || !out_stall;
  assign load_out  = (uw.op == s2c_pkg::OP_OUT) && out_free;
  assign yl        = 8'(year_r - s2c_pkg::CENTURY_REF);

  assign in_stall = (uw.op != s2c_pkg::OP_WAIT);

  // Step sequencing.
  always_comb begin
    step_nxt = step_r + 1'b1;
    unique case (uw.op)
      s2c_pkg::OP_WAIT:     if (!in_valid) step_nxt = step_r;
      s2c_pkg::OP_YEAR:     if (!year_done) step_nxt = step_r;
      s2c_pkg::OP_MONTH:    if (!mon_done) step_nxt = step_r;
      s2c_pkg::OP_OUT:      step_nxt = out_free ? s2c_pkg::STEP_WAIT : step_r;
      default:              step_nxt = step_r + 1'b1;
    endcase
  end

  // Datapath controlled by the current control word.
  always_comb begin
    num_nxt  = num_r;
    quo_nxt  = quo_r;
    days_nxt = days_r;
    year_nxt = year_r;
    mon_nxt  = mon_r;
    hour_nxt = hour_r;
    min_nxt  = min_r;
    sec_nxt  = sec_r;
    flag_nxt = flag_r;
    unique case (uw.op)
      s2c_pkg::OP_WAIT: begin
        if (in_valid) begin
          if (in_epoch_seconds > s2c_pkg::LAST_SECOND) begin
            num_nxt  = s2c_pkg::LAST_SECOND;
            flag_nxt = 1'b1;
          end else begin
            num_nxt  = in_epoch_seconds;
            flag_nxt = 1'b0;
          end
        end
      end
      s2c_pkg::OP_DIV_QUO: quo_nxt = s2c_pkg::div_quo(uw.dsel, num_r);
      s2c_pkg::OP_DIV_REM: num_nxt = s2c_pkg::div_rem(uw.dsel, num_r, quo_r);
      s2c_pkg::OP_SAVE_DAYS: begin
        days_nxt = quo_r;
        year_nxt = s2c_pkg::BASE_YEAR;
      end
      s2c_pkg::OP_SAVE_HOUR: hour_nxt = quo_r[4:0];
      s2c_pkg::OP_SAVE_MIN: begin
        min_nxt = quo_r[5:0];
        sec_nxt = num_r[5:0];
        mon_nxt = '0;
      end
      s2c_pkg::OP_YEAR: begin
        if (!year_done) begin
          days_nxt = days_r - {7'd0, ylen};
          year_nxt = year_r + 12'd1;
        end
      end
      s2c_pkg::OP_MONTH: begin
        if (!mon_done) begin
          days_nxt = days_r - {11'd0, mlen};
          mon_nxt  = mon_r + 4'd1;
        end
      end
      s2c_pkg::OP_WD_PREP: num_nxt = {23'd0, {1'b0, yl} + {3'd0, yl[7:2]}};
      s2c_pkg::OP_WD_ADD: begin
        // Year term plus day of month and the month offset, reduced modulo 7 next;
        // January and February of a leap year count one less.
        num_nxt = {23'd0, 9'(num_r[8:0] + {3'd0, days_r[5:0]} + 9'd1
                             + {6'd0, s2c_pkg::month_offset(mon_r)}
                             - {8'd0, leap && (mon_r < 4'd2)})};
      end
      s2c_pkg::OP_OUT: ;
      default: ;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      step_r      <= s2c_pkg::STEP_WAIT;
      out_valid_r <= 1'b0;
    end else begin
      step_r <= step_nxt;
      if (load_out)       out_valid_r <= 1'b1;
      else if (!out_stall) out_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    num_r  <= num_nxt;
    quo_r  <= quo_nxt;
    days_r <= days_nxt;
    year_r <= year_nxt;
    mon_r  <= mon_nxt;
    hour_r <= hour_nxt;
    min_r  <= min_nxt;
    sec_r  <= sec_nxt;
    flag_r <= flag_nxt;
    if (load_out) begin
      out_year         <= year_r;
      out_month        <= mon_r + 4'd1;
      out_day_of_month <= days_r[4:0] + 5'd1;
      out_hour         <= hour_r;
      out_minute       <= min_r;
      out_second       <= sec_r;
      out_weekday      <= num_r[2:0];
      out_beyond_range <= flag_r;
    end
  end

  assign out_valid = out_valid_r;

endmodule

`default_nettype wire
